// ===== src/pretrigger_crash_capture_assert.svh =====
// assertion macros used by the checker file
`ifndef PRETRIGGER_CRASH_CAPTURE_ASSERT_SVH
`define PRETRIGGER_CRASH_CAPTURE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcc_pkg.sv =====
// shared types, constants and helpers for the pretrigger crash capture block
`timescale 1ns / 1ps

package pcc_pkg;

  localparam int          DEPTH_DEFAULT    = 10;
  localparam int          THRESH_W         = 15;
  localparam int          SAMPLE_W         = 16;
  localparam int          NUM_W            = 4;
  localparam logic [14:0] THRESH_RESET     = 15'd2000;

  // one stored three-axis reading
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } reading_t;

  // chain control from the sequencer to the cells
  typedef struct packed {
    logic shift;   // new sample enters at the head
    logic rotate;  // tail wraps back to the head
  } chain_ctl_t;

  // 17-bit magnitude, so -32768 gives 32768
  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

endpackage

// ===== src/pcc_in_if.sv =====
// sample input channel: valid, ready and one three-axis sample
`timescale 1ns / 1ps

interface pcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_sample;
  logic signed [15:0] y_sample;
  logic signed [15:0] z_sample;

  modport source(output valid, output x_sample, output y_sample, output z_sample,
                 input ready);
  modport sink(input valid, input x_sample, input y_sample, input z_sample,
               output ready);
endinterface

// ===== src/pcc_out_if.sv =====
// result channel: valid, ready and one dumped or echoed reading
`timescale 1ns / 1ps

interface pcc_out_if;
  logic               valid;
  logic               ready;
  logic               crash_alarm;
  logic [3:0]         reading_number;
  logic signed [15:0] hist_x;
  logic signed [15:0] hist_y;
  logic signed [15:0] hist_z;
  logic               last_of_run;

  modport source(output valid, output crash_alarm, output reading_number,
                 output hist_x, output hist_y, output hist_z, output last_of_run,
                 input ready);
  modport sink(input valid, input crash_alarm, input reading_number,
               input hist_x, input hist_y, input hist_z, input last_of_run,
               output ready);
endinterface

// ===== src/pcc_cell.sv =====
// one history cell: holds a reading and takes its neighbor's on each move
`timescale 1ns / 1ps

module pcc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  pcc_pkg::chain_ctl_t ctl,
  input  pcc_pkg::reading_t   d,
  output pcc_pkg::reading_t   q
);
  import pcc_pkg::*;

  reading_t data_r;

  // history is cleared to zero at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (ctl.shift || ctl.rotate) begin
      data_r <= d;
    end
  end

  assign q = data_r;
endmodule

// ===== src/pcc_chain.sv =====
// row of history cells, newest at the head, oldest at the tail
`timescale 1ns / 1ps

module pcc_chain #(
  parameter int DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcc_pkg::chain_ctl_t ctl,
  input  pcc_pkg::reading_t   new_reading,
  output pcc_pkg::reading_t   tail
);
  import pcc_pkg::*;

  reading_t taps [DEPTH];
  reading_t head_in;

  // head takes the new sample, or the tail while the dump rotates the row
  assign head_in = ctl.rotate ? taps[DEPTH-1] : new_reading;

  // cells, each fed by its upstream neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      pcc_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d(head_in), .q(taps[i]));
    end else begin : g_body
      pcc_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(ctl), .d(taps[i-1]), .q(taps[i]));
    end
  end

  assign tail = taps[DEPTH-1];
endmodule

// ===== src/pretrigger_crash_capture.sv =====
// top level: threshold trigger, dump sequencer and output register over the history row
// echo: a quiet sample's echo beat is registered and appears in the cycle after acceptance
// dump: a crash moves the sequencer into the dump state, then one beat per cycle while the output is not stalled
// throughput: 1 sample per cycle when quiet and the output is not stalled; a crash refuses the input
//   for the whole dump, while the cell row rotates one place per dump beat
// reset: synchronous active-low rst_n zeroes the history, threshold returns to 2000
`timescale 1ns / 1ps

module pretrigger_crash_capture #(
  parameter int HISTORY_DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  pcc_in_if.sink      in_chan,
  pcc_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata
);
  import pcc_pkg::*;

  localparam int             CW       = $clog2(HISTORY_DEPTH);
  localparam logic [CW-1:0]  LAST_IDX = CW'(HISTORY_DEPTH - 1);
  localparam logic           ST_IDLE  = 1'b0;
  localparam logic           ST_DUMP  = 1'b1;

  logic               state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [14:0]        thresh_r;
  logic               out_valid_r, out_valid_nxt;
  logic               alarm_r, alarm_nxt;
  logic [3:0]         num_r, num_nxt;
  reading_t           data_r, data_nxt;
  logic               last_r, last_nxt;

  logic               out_free;
  logic               in_ready;
  logic               in_fire;
  logic               dump_step;
  logic               crash;
  reading_t           sample;
  reading_t           tail;
  chain_ctl_t         ctl;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  // handshake
  assign out_free  = !out_valid_r || out_chan.ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_chan.valid && in_ready;
  assign dump_step = (state_r == ST_DUMP) && out_free;
  assign in_chan.ready = in_ready;

  // trigger on |x| or |y| strictly above threshold
  assign sample.x = in_chan.x_sample;
  assign sample.y = in_chan.y_sample;
  assign sample.z = in_chan.z_sample;
  assign crash = (mag17(sample.x) > {2'b00, thresh_r}) ||
                 (mag17(sample.y) > {2'b00, thresh_r});

  // history row
  assign ctl.shift  = in_fire;
  assign ctl.rotate = dump_step;

  pcc_chain #(.DEPTH(HISTORY_DEPTH)) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .new_reading(sample),
    .tail       (tail)
  );

  // dump sequencer and output register next values
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    alarm_nxt     = alarm_r;
    num_nxt       = num_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (crash) begin
            state_nxt = ST_DUMP;
            cnt_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
            alarm_nxt     = 1'b0;
            num_nxt       = '0;
            data_nxt      = sample;
            last_nxt      = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          out_valid_nxt = 1'b1;
          alarm_nxt     = 1'b1;
          num_nxt       = 4'(cnt_r) + 4'd1;
          data_nxt      = tail;
          last_nxt      = (cnt_r == LAST_IDX);
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    alarm_r <= alarm_nxt;
    num_r   <= num_nxt;
    data_r  <= data_nxt;
    last_r  <= last_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.crash_alarm    = alarm_r;
  assign out_chan.reading_number = num_r;
  assign out_chan.hist_x         = data_r.x;
  assign out_chan.hist_y         = data_r.y;
  assign out_chan.hist_z         = data_r.z;
  assign out_chan.last_of_run    = last_r;
endmodule

// ===== src/pcc_checker.sv =====
// port-level checker for the pretrigger crash capture block, bound to the top level
`timescale 1ns / 1ps

`include "pretrigger_crash_capture_assert.svh"

module pcc_checker #(
  parameter int HISTORY_DEPTH = pcc_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        crash_alarm,
  input logic [3:0]  reading_number,
  input logic [15:0] hist_x,
  input logic        last_of_run
);
  localparam logic [3:0] LAST_NUM = 4'(HISTORY_DEPTH);

  // a stalled beat keeps its data
  `PCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hist_x) && $stable(reading_number), "stalled result beat changed")

  // a quiet echo is a single beat numbered zero
  `PCC_ASSERT_IMP(a_echo_shape, out_valid && !crash_alarm, last_of_run && (reading_number == 4'd0), "echo beat malformed")

  // the last dump beat carries the depth as its number
  `PCC_ASSERT_IMP(a_dump_last_num, out_valid && crash_alarm && last_of_run, reading_number == LAST_NUM, "dump ended at wrong reading")

  // no new sample is taken in the middle of a dump
  `PCC_ASSERT_IMP(a_no_take_mid_dump, out_valid && crash_alarm && !last_of_run, !in_ready, "sample taken during dump")
endmodule

bind pretrigger_crash_capture pcc_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_pcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .crash_alarm   (out_chan.crash_alarm),
  .reading_number(out_chan.reading_number),
  .hist_x        (out_chan.hist_x),
  .last_of_run   (out_chan.last_of_run)
);
